// File: rtl/pqta_pkg.sv
// Shared types and constants for the pending query table with aging.
// Holds the table size, request and status codes, controller states and
// the command and status structs that join the controller and datapath.
`default_nettype none

package pqta_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 128;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = SLOT_W + 1;

  // Field widths of the item ports.
  localparam int ID_W       = 16;
  localparam int TAG_W      = 32;
  localparam int LIFE_W     = 8;
  localparam int OUT_SLOT_W = 7;

  localparam logic [LIFE_W-1:0] DEFAULT_LIFETIME = LIFE_W'(6);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_FIND,
    S_TICK,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;        // latch the request and restart the scan
    logic    issue;       // read the slot under the scan counter and advance
    logic    add_wr;      // write the new entry at the scan counter
    logic    hit_search;  // take slot and tag of the matching entry
    logic    hit_delete;  // take slot of the matching entry and free it
    logic    tick_en;     // age the entries coming out of the read stage
    logic    set_status;  // overwrite the result status
    status_t status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic free_hit;   // slot under the scan counter is free
    logic add_last;   // scan counter is on the last slot
    logic match_hit;  // read stage holds a valid entry with the request id
    logic scan_done;  // every slot has been read and the read stage is empty
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/pqta_dp.sv
// Datapath of the pending query table: valid flags, id, tag and lifetime
// memories, scan counter, read stage, result registers and lifetime register.
// Depends on pqta_pkg for sizes and the command and status structs.
`default_nettype none

module pqta_dp
  import pqta_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire logic [ID_W-1:0]       in_query_id,
  input  wire logic [TAG_W-1:0]      in_entry_tag,
  input  wire logic                  cfg_we,
  input  wire logic [LIFE_W-1:0]     cfg_wdata,
  output logic      [1:0]            res_status,
  output logic      [OUT_SLOT_W-1:0] res_slot_index,
  output logic      [TAG_W-1:0]      res_found_tag
);

  logic [LIFE_W-1:0]        lifetime_r;
  logic [ID_W-1:0]          req_id_r;
  logic [TAG_W-1:0]         req_tag_r;
  logic [CNT_W-1:0]         iss_r;
  logic [SLOT_W-1:0]        iss_idx;
  logic                     iss_live;
  logic                     p_vld_r;
  logic [SLOT_W-1:0]        p_idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [ID_W-1:0]   id_mem   [TABLE_ENTRIES];
  logic [TAG_W-1:0]  tag_mem  [TABLE_ENTRIES];
  logic [LIFE_W-1:0] life_mem [TABLE_ENTRIES];
  logic [ID_W-1:0]   id_rd_r;
  logic [TAG_W-1:0]  tag_rd_r;
  logic [LIFE_W-1:0] life_rd_r;

  logic              tick_act;
  logic [LIFE_W-1:0] life_dec;
  logic              life_we;
  logic [SLOT_W-1:0] life_waddr;
  logic [LIFE_W-1:0] life_wdata;

  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [TAG_W-1:0]  res_tag_r;

  assign iss_idx  = iss_r[SLOT_W-1:0];
  assign iss_live = (iss_r != CNT_W'(TABLE_ENTRIES));

  // Lifetime register, written by the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= DEFAULT_LIFETIME;
    end else if (cfg_we) begin
      lifetime_r <= cfg_wdata;
    end
  end

  // Request payload is latched when an item is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_id_r  <= in_query_id;
      req_tag_r <= in_entry_tag;
    end
  end

  // Scan counter and read stage tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r   <= '0;
      p_vld_r <= 1'b0;
    end else if (cmd.load) begin
      iss_r   <= '0;
      p_vld_r <= 1'b0;
    end else begin
      if (cmd.issue && iss_live) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      p_vld_r <= cmd.issue && iss_live;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r <= iss_idx;
  end

  // Memory reads with registered data.
  always_ff @(posedge clk) begin
    id_rd_r   <= id_mem[iss_idx];
    tag_rd_r  <= tag_mem[iss_idx];
    life_rd_r <= life_mem[iss_idx];
  end

  // Aging of the entry in the read stage.
  assign tick_act = cmd.tick_en && p_vld_r && valid_r[p_idx_r];
  assign life_dec = life_rd_r - LIFE_W'(1);

  always_comb begin
    life_we    = cmd.add_wr || tick_act;
    life_waddr = cmd.add_wr ? iss_idx : p_idx_r;
    life_wdata = cmd.add_wr ? lifetime_r : life_dec;
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      id_mem[iss_idx]  <= req_id_r;
      tag_mem[iss_idx] <= req_tag_r;
    end
    if (life_we) begin
      life_mem[life_waddr] <= life_wdata;
    end
  end

  // Valid flags: set on add, cleared on delete and on expiry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.add_wr) begin
        valid_r[iss_idx] <= 1'b1;
      end
      if (cmd.hit_delete || (tick_act && (life_dec == '0))) begin
        valid_r[p_idx_r] <= 1'b0;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_status_r <= ST_OK;
    end else if (cmd.load) begin
      res_status_r <= ST_OK;
    end else if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_slot_r <= '0;
      res_tag_r  <= '0;
    end else if (cmd.add_wr) begin
      res_slot_r <= iss_idx;
    end else if (cmd.hit_search) begin
      res_slot_r <= p_idx_r;
      res_tag_r  <= tag_rd_r;
    end else if (cmd.hit_delete) begin
      res_slot_r <= p_idx_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.free_hit  = iss_live && !valid_r[iss_idx];
    sts.add_last  = (iss_r == CNT_W'(TABLE_ENTRIES - 1));
    sts.match_hit = p_vld_r && valid_r[p_idx_r] && (id_rd_r == req_id_r);
    sts.scan_done = !iss_live && !p_vld_r;
  end

  assign res_status     = res_status_r;
  assign res_slot_index = OUT_SLOT_W'(res_slot_r);
  assign res_found_tag  = res_tag_r;

endmodule

`default_nettype wire

// File: rtl/pqta_ctrl.sv
// Controller of the pending query table: sequences the slot scan for each
// request and drives the datapath through command and status structs.
// Depends on pqta_pkg for request codes, states and the structs.
`default_nettype none

module pqta_ctrl
  import pqta_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_req_type,
  input  wire dp_sts_t    sts,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            out_valid
);

  state_t state_r, state_nxt;
  req_t   req_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request type of the item being worked on.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= req_t'(in_req_type);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (req_t'(in_req_type)) inside
            REQ_ADD:                state_nxt = S_ADD;
            REQ_SEARCH, REQ_DELETE: state_nxt = S_FIND;
            REQ_TICK:               state_nxt = S_TICK;
            default:                state_nxt = S_TICK;
          endcase
        end
      end
      S_ADD: begin
        if (sts.free_hit || sts.add_last) begin
          state_nxt = S_RESP;
        end
      end
      S_FIND: begin
        if (sts.match_hit || sts.scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_TICK: begin
        if (sts.scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd       = '0;
    cmd.status = ST_OK;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_ADD: begin
        if (sts.free_hit) begin
          cmd.add_wr = 1'b1;
        end else if (sts.add_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_FIND: begin
        cmd.issue = 1'b1;
        if (sts.match_hit) begin
          cmd.hit_search = (req_r == REQ_SEARCH);
          cmd.hit_delete = (req_r != REQ_SEARCH);
        end else if (sts.scan_done) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
        end
      end
      S_TICK: begin
        cmd.issue   = 1'b1;
        cmd.tick_en = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/pending_query_table_with_aging.sv
// Pending query table with timeout aging: top level.
// An item (in_req_type, in_query_id, in_entry_tag) is taken at a clock edge
// where start is high and busy is low. Request types are add, search,
// delete and tick. Busy stays high until the result has been shown.
// The result (out_status, out_slot_index, out_found_tag) is on the out_
// ports for exactly one cycle, marked by out_valid; the receiver cannot
// stall, so it must take it in that cycle. Busy falls the cycle after.
// Each request scans the 128 slots one per clock through a single memory
// read port; a match or free slot ends the scan early. The next item can
// be taken in the cycle after out_valid.
// cfg_we with cfg_wdata loads the lifetime given to new entries; write it
// only while busy is low. Reset (rst_n low, synchronous) clears all valid
// flags at once and sets the lifetime to 6; no clearing pass is needed.
// Depends on pqta_pkg, pqta_ctrl and pqta_dp.
`default_nettype none

module pending_query_table_with_aging
  import pqta_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [ID_W-1:0]       in_query_id,
  input  wire logic [TAG_W-1:0]      in_entry_tag,
  output logic                       out_valid,
  output logic      [1:0]            out_status,
  output logic      [OUT_SLOT_W-1:0] out_slot_index,
  output logic      [TAG_W-1:0]      out_found_tag,
  input  wire logic                  cfg_we,
  input  wire logic [LIFE_W-1:0]     cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pqta_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  pqta_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_query_id    (in_query_id),
    .in_entry_tag   (in_entry_tag),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .res_status     (out_status),
    .res_slot_index (out_slot_index),
    .res_found_tag  (out_found_tag)
  );

`ifndef SYNTHESIS
  // An accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an item was accepted");

  // A result strobe lasts one cycle and is followed by idle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle or block not idle after it");

  // The strobe only comes while the block is busy.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // Failed requests report slot zero and tag zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_NOT_FOUND)) |->
      (out_slot_index == '0 && out_found_tag == '0))
    else $error("failed request reported a nonzero slot or tag");
`endif

endmodule

`default_nettype wire
